/* design/ccc_pkg.sv */
// ----------------------------------------------------------------------------
// ccc_pkg: shared types and calendar helpers for the clock/calendar counter
// Holds the time record, the input item layout, month lengths and the
// Gregorian leap-year test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ccc_pkg;

  localparam int unsigned YearW = 14;

  localparam logic [5:0] SecMaxC   = 6'd59;
  localparam logic [5:0] MinMaxC   = 6'd59;
  localparam logic [4:0] HourMaxC  = 5'd23;
  localparam logic [5:0] LeapDayC  = 6'd29;
  localparam logic [3:0] MonthJanC = 4'd1;
  localparam logic [3:0] MonthFebC = 4'd2;
  localparam logic [3:0] MonthDecC = 4'd12;
  localparam logic [4:0] DayFirstC = 5'd1;

  // Multiplicative inverse of 25 modulo 2**14 and the divisibility limit
  // floor((2**14 - 1) / 25). A 14-bit value is a multiple of 25 exactly
  // when its product with the inverse, modulo 2**14, is at most the limit.
  localparam logic [YearW-1:0] Inv25C    = 14'd7209;
  localparam logic [YearW-1:0] Div25LimC = 14'd655;

  typedef struct packed {
    logic [YearW-1:0] year;
    logic [3:0]       month;
    logic [4:0]       day;
    logic [4:0]       hour;
    logic [5:0]       minute;
    logic [5:0]       second;
  } ccc_time_t;

  typedef struct packed {
    logic      mode;   // 0: one-second tick, 1: load
    ccc_time_t load;
  } ccc_item_t;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Leap when divisible by 4 and not by 100, or divisible by 400.
  // With divisibility by 4 given, 100 | y reduces to 25 | y and
  // 400 | y to 25 | y with y also divisible by 16.
  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic [YearW-1:0] prod;
    logic             div25;
    prod  = YearW'(y * Inv25C);
    div25 = (prod <= Div25LimC);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:2] == 2'b00));
  endfunction

  function automatic logic day_ok(input logic [5:0] d, input logic [3:0] m,
                                  input logic [YearW-1:0] y);
    logic [4:0] len;
    len = month_len(m);
    return ((d != 6'd0) && (d <= {1'b0, len})) ||
           ((m == MonthFebC) && (d == LeapDayC) && is_leap(y));
  endfunction

endpackage

`default_nettype wire

/* design/ccc_in_stage.sv */
// ----------------------------------------------------------------------------
// ccc_in_stage: input register of the clock/calendar counter
// Captures one item per cycle while ready; holds it until the core takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccc_in_stage
  import ccc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire ccc_item_t in_item_i,
  output logic           item_valid_o,
  input  wire logic      item_take_i,
  output ccc_item_t      item_o
);

  logic      valid_q, valid_d;
  ccc_item_t item_q;

  assign in_ready_o = !valid_q || item_take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

/* design/ccc_core.sv */
// ----------------------------------------------------------------------------
// ccc_core: time and date counters with tick and checked-load update
// Holds the clock state and computes the state after one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccc_core
  import ccc_pkg::*;
#(
  parameter int unsigned LAST_YEAR = 9999
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      step_i,
  input  wire ccc_item_t item_i,
  output ccc_time_t      next_o,
  output logic           err_o
);

  localparam logic [YearW-1:0] LastYearC = YearW'(LAST_YEAR);

  ccc_time_t cur_q, cur_d;
  logic      err;
  logic      load_ok;
  logic [5:0] day_inc;

  assign day_inc = {1'b0, cur_q.day} + 6'd1;

  always_comb begin
    ccc_time_t ld;
    ld      = item_i.load;
    cur_d   = cur_q;
    err     = 1'b0;
    load_ok = (ld.month >= MonthJanC) && (ld.month <= MonthDecC) &&
              (ld.year <= LastYearC) &&
              day_ok({1'b0, ld.day}, ld.month, ld.year) &&
              (ld.hour <= HourMaxC) && (ld.minute <= MinMaxC) &&
              (ld.second <= SecMaxC);
    if (item_i.mode == MODE_TICK) begin
      if (cur_q.second < SecMaxC) begin
        cur_d.second = cur_q.second + 6'd1;
      end else begin
        cur_d.second = '0;
        if (cur_q.minute < MinMaxC) begin
          cur_d.minute = cur_q.minute + 6'd1;
        end else begin
          cur_d.minute = '0;
          if (cur_q.hour < HourMaxC) begin
            cur_d.hour = cur_q.hour + 5'd1;
          end else begin
            cur_d.hour = '0;
            if (day_ok(day_inc, cur_q.month, cur_q.year)) begin
              cur_d.day = day_inc[4:0];
            end else begin
              cur_d.day = DayFirstC;
              if (cur_q.month >= MonthDecC) begin
                cur_d.month = MonthJanC;
                cur_d.year  = (cur_q.year >= LastYearC) ? '0 :
                              cur_q.year + YearW'(1);
              end else begin
                cur_d.month = cur_q.month + 4'd1;
              end
            end
          end
        end
      end
    end else if (load_ok) begin
      cur_d = ld;
    end else begin
      err = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q.second <= '0;
      cur_q.minute <= '0;
      cur_q.hour   <= '0;
      cur_q.day    <= DayFirstC;
      cur_q.month  <= MonthJanC;
      cur_q.year   <= YearW'(2000);
    end else if (step_i) begin
      cur_q <= cur_d;
    end
  end

  assign next_o = cur_d;
  assign err_o  = err;

endmodule

`default_nettype wire

/* design/calendar_clock_counter_unit.sv */
// ----------------------------------------------------------------------------
// calendar_clock_counter_unit: real-time clock with Gregorian calendar
// Counts seconds through years on tick items and takes checked loads.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one item per cycle when ready; s_axis_tuser
//   selects the kind: 0 is a one-second tick, 1 a load of the date and time
//   carried in s_axis_tdata (ignored on a tick). Every item yields exactly
//   one result item on the master channel: the clock after that item, with
//   m_axis_tuser high when a load was rejected and the clock kept.
//   From acceptance, an item passes the input register, then the update
//   logic into the result register, which drives m_axis_tvalid.
//   Throughput is one item per cycle while the receiver does not stall; the
//   combinational counter update feeds the state back for the next item.
//   When the receiver stalls, the result register holds its item and the
//   input register still takes one more item; after that s_axis_tready
//   drops until m_axis_tready returns.
//   Reset clears both registers and sets the clock to 00:00:00 on
//   January 1, 2000. The year wraps from LAST_YEAR to 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module calendar_clock_counter_unit
  import ccc_pkg::*;
#(
  parameter int unsigned LAST_YEAR = 9999
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // load_second[5:0], load_minute[11:6], load_hour[16:12], load_day[21:17],
  // load_month[25:22], load_year[39:26]
  input  wire logic [39:0] s_axis_tdata,
  // mode[0]
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // cur_second[5:0], cur_minute[11:6], cur_hour[16:12], cur_day[21:17],
  // cur_month[25:22], cur_year[39:26]
  output logic [39:0]      m_axis_tdata,
  // load_error[0]
  output logic             m_axis_tuser
);

  ccc_item_t in_item;
  ccc_item_t stage_item;
  logic      stage_valid;
  logic      step;
  logic      out_free;
  ccc_time_t next_time;
  logic      next_err;

  logic      out_valid_q, out_valid_d;
  ccc_time_t out_time_q;
  logic      out_err_q;

  assign in_item.mode        = s_axis_tuser;
  assign in_item.load.second = s_axis_tdata[5:0];
  assign in_item.load.minute = s_axis_tdata[11:6];
  assign in_item.load.hour   = s_axis_tdata[16:12];
  assign in_item.load.day    = s_axis_tdata[21:17];
  assign in_item.load.month  = s_axis_tdata[25:22];
  assign in_item.load.year   = s_axis_tdata[39:26];

  assign out_free = !out_valid_q || m_axis_tready;
  assign step     = stage_valid && out_free;

  ccc_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .item_valid_o (stage_valid),
    .item_take_i  (step),
    .item_o       (stage_item)
  );

  ccc_core #(
    .LAST_YEAR (LAST_YEAR)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (stage_item),
    .next_o (next_time),
    .err_o  (next_err)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = stage_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_time_q <= next_time;
      out_err_q  <= next_err;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_time_q.year, out_time_q.month, out_time_q.day,
                          out_time_q.hour, out_time_q.minute, out_time_q.second};
  assign m_axis_tuser  = out_err_q;

endmodule

`default_nettype wire

/* sim/tb_calendar_clock_counter_unit.sv */
// ----------------------------------------------------------------------------
// tb_calendar_clock_counter_unit: self-checking bench for the clock/calendar
// Drives tick and load items into the slave stream, predicts every reading
// with a behavioral calendar model, and compares each result item field by
// field as it leaves the master stream under random sender and receiver gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_calendar_clock_counter_unit;
  import ccc_pkg::*;

  localparam int unsigned LastYear = 9999;

  typedef struct {
    ccc_time_t clock;
    logic      rejected;
  } rtc_reading_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // load_second[5:0], load_minute[11:6], load_hour[16:12], load_day[21:17],
  // load_month[25:22], load_year[39:26]
  logic [39:0] s_axis_tdata  = '0;
  // mode[0]
  logic        s_axis_tuser  = MODE_TICK;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // cur_second[5:0], cur_minute[11:6], cur_hour[16:12], cur_day[21:17],
  // cur_month[25:22], cur_year[39:26]
  logic [39:0] m_axis_tdata;
  // load_error[0]
  logic        m_axis_tuser;

  ccc_time_t    rtc_state;
  rtc_reading_t pending_readings[$];
  int unsigned  mismatches = 0;
  int unsigned  idle_pct   = 0;
  int unsigned  stall_pct  = 0;

  calendar_clock_counter_unit #(
    .LAST_YEAR(LastYear)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned days_in_month(input logic [3:0] m, input int unsigned y);
    int unsigned len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 30;
      4'd2: len = ((y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0))) ? 29 : 28;
      default:                                    len = 0;
    endcase
    return len;
  endfunction

  function automatic ccc_time_t make_time(input int unsigned y, input int unsigned mo,
                                          input int unsigned d, input int unsigned h,
                                          input int unsigned mi, input int unsigned s);
    ccc_time_t t;
    t.year   = YearW'(y);
    t.month  = 4'(mo);
    t.day    = 5'(d);
    t.hour   = 5'(h);
    t.minute = 6'(mi);
    t.second = 6'(s);
    return t;
  endfunction

  // Advances the calendar by one item and returns the reading that follows it.
  function automatic rtc_reading_t rtc_update(input logic mode, input ccc_time_t ld);
    rtc_reading_t r;
    logic         ok;
    r.rejected = 1'b0;
    if (mode == MODE_TICK) begin
      if (rtc_state.second < SecMaxC) begin
        rtc_state.second = rtc_state.second + 6'd1;
      end else begin
        rtc_state.second = '0;
        if (rtc_state.minute < MinMaxC) begin
          rtc_state.minute = rtc_state.minute + 6'd1;
        end else begin
          rtc_state.minute = '0;
          if (rtc_state.hour < HourMaxC) begin
            rtc_state.hour = rtc_state.hour + 5'd1;
          end else begin
            rtc_state.hour = '0;
            if (rtc_state.day < days_in_month(rtc_state.month, rtc_state.year)) begin
              rtc_state.day = rtc_state.day + 5'd1;
            end else begin
              rtc_state.day = 5'd1;
              if (rtc_state.month >= 4'd12) begin
                rtc_state.month = 4'd1;
                rtc_state.year  = (rtc_state.year >= LastYear) ? '0 : rtc_state.year + 1'b1;
              end else begin
                rtc_state.month = rtc_state.month + 4'd1;
              end
            end
          end
        end
      end
    end else begin
      ok = (ld.year <= LastYear) && (ld.day >= 1) &&
           (ld.day <= days_in_month(ld.month, ld.year)) &&
           (ld.hour <= 23) && (ld.minute <= 59) && (ld.second <= 59);
      if (ok) begin
        rtc_state = ld;
      end else begin
        r.rejected = 1'b1;
      end
    end
    r.clock = rtc_state;
    return r;
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 40) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    end
  endtask

  // Predicts on every accepted input item and checks every accepted result item.
  always @(posedge clk_i) begin
    rtc_reading_t want;
    ccc_time_t    seen;
    if (!rst_ni) begin
      rtc_state = make_time(2000, 1, 1, 0, 0, 0);
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pending_readings.push_back(rtc_update(s_axis_tuser, s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen = m_axis_tdata;
        if (pending_readings.size() == 0) begin
          mismatches++;
          if (mismatches <= 40) begin
            $display("%0t ns: result with nothing expected, actual %h / %b",
                     $time, m_axis_tdata, m_axis_tuser);
          end
        end else begin
          want = pending_readings.pop_front();
          check_field("cur_second", want.clock.second, seen.second);
          check_field("cur_minute", want.clock.minute, seen.minute);
          check_field("cur_hour", want.clock.hour, seen.hour);
          check_field("cur_day", want.clock.day, seen.day);
          check_field("cur_month", want.clock.month, seen.month);
          check_field("cur_year", want.clock.year, seen.year);
          check_field("load_error", want.rejected, m_axis_tuser);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Presents one item after a random gap and returns at the edge that takes it.
  task automatic send_item(input logic mode, input ccc_time_t data);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= mode;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
  endtask

  task automatic test_directed_cases();
    idle_pct  = 0;
    stall_pct = 0;
    send_item(MODE_TICK, '0);
    // Last second of the last year wraps to the start of year 0.
    send_item(MODE_LOAD, make_time(LastYear, 12, 31, 23, 59, 59));
    send_item(MODE_TICK, '0);
    // Century leap year, plain century, ordinary leap year.
    send_item(MODE_LOAD, make_time(2000, 2, 28, 23, 59, 59));
    send_item(MODE_TICK, '0);
    send_item(MODE_LOAD, make_time(1900, 2, 28, 23, 59, 59));
    send_item(MODE_TICK, '0);
    send_item(MODE_LOAD, make_time(2024, 2, 29, 23, 59, 59));
    send_item(MODE_TICK, '0);
    send_item(MODE_LOAD, make_time(2023, 2, 29, 12, 0, 0));
    send_item(MODE_LOAD, make_time(2100, 2, 29, 12, 0, 0));
    send_item(MODE_LOAD, make_time(2400, 2, 29, 12, 0, 0));
    // Each field just out of range is rejected on its own.
    send_item(MODE_LOAD, make_time(2010, 0, 10, 1, 1, 1));
    send_item(MODE_LOAD, make_time(2010, 13, 10, 1, 1, 1));
    send_item(MODE_LOAD, make_time(2010, 5, 0, 1, 1, 1));
    send_item(MODE_LOAD, make_time(2010, 4, 31, 1, 1, 1));
    send_item(MODE_LOAD, make_time(2010, 5, 10, 24, 1, 1));
    send_item(MODE_LOAD, make_time(2010, 5, 10, 1, 60, 1));
    send_item(MODE_LOAD, make_time(2010, 5, 10, 1, 1, 60));
    send_item(MODE_LOAD, make_time(LastYear + 1, 5, 10, 1, 1, 1));
    send_item(MODE_LOAD, '1);
    send_item(MODE_LOAD, make_time(0, 1, 1, 0, 0, 0));
    send_item(MODE_LOAD, make_time(1999, 4, 30, 23, 59, 59));
    // A tick ignores whatever the load fields carry.
    send_item(MODE_TICK, '1);
  endtask

  task automatic run_random_stream(input int unsigned count);
    int unsigned pick;
    int unsigned y;
    int unsigned m;
    int unsigned len;
    ccc_time_t   data;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        data = 40'({$urandom(), $urandom()});
        send_item(MODE_TICK, data);
      end else if (pick < 90) begin
        // Loads close to a rollover so that the following ticks carry far.
        case ($urandom_range(3))
          0:       y = $urandom_range(LastYear);
          1:       y = LastYear - $urandom_range(3);
          2:       y = $urandom_range(LastYear / 100) * 100;
          default: y = $urandom_range(LastYear / 4) * 4;
        endcase
        case ($urandom_range(2))
          0:       m = $urandom_range(1, 12);
          1:       m = 2;
          default: m = 12;
        endcase
        len = days_in_month(4'(m), y);
        data.year   = YearW'(y);
        data.month  = 4'(m);
        data.day    = 5'($urandom_range(1) ? len - $urandom_range(1) : $urandom_range(1, len));
        data.hour   = 5'($urandom_range(1) ? 23 : $urandom_range(23));
        data.minute = 6'($urandom_range(1) ? 59 : $urandom_range(59));
        data.second = 6'($urandom_range(1) ? $urandom_range(55, 59) : $urandom_range(59));
        // A few of them name the day after the end of the month.
        if (pick >= 87) begin
          data.day = 5'(len + 1);
        end
        send_item(MODE_LOAD, data);
      end else begin
        data = 40'({$urandom(), $urandom()});
        send_item(MODE_LOAD, data);
      end
    end
  endtask

  task automatic test_stream_no_idle();
    idle_pct  = 0;
    stall_pct = 0;
    run_random_stream(430);
  endtask

  task automatic test_stream_sender_idle();
    idle_pct  = 73;
    stall_pct = 0;
    run_random_stream(430);
  endtask

  task automatic test_stream_receiver_stall();
    idle_pct  = 0;
    stall_pct = 73;
    run_random_stream(430);
  endtask

  task automatic test_stream_both_idle();
    idle_pct  = 12;
    stall_pct = 12;
    run_random_stream(440);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_stream_no_idle();
    test_stream_sender_idle();
    test_stream_receiver_stall();
    test_stream_both_idle();
    s_axis_tvalid <= 1'b0;
    // The last item is queued at the edge that took it, so wait for an edge before checking the queue.
    @(posedge clk_i);
    while (pending_readings.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
